### design/rvm_pkg.sv
package rvm_pkg;

    // Field widths of the item and result channels.
    localparam int ACT_W      = 2;
    localparam int INDEX_W    = 12;
    localparam int SAMPLE_W   = 16;
    localparam int STEP_W     = 20;
    localparam int FRAMES_W   = 13;
    localparam int POS_W      = 32;
    localparam int FRAC_W     = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 20;

    // Action codes carried by an input item.
    localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_START = 2'd1;
    localparam logic [ACT_W-1:0] ACT_STOP  = 2'd2;
    localparam logic [ACT_W-1:0] ACT_MIX   = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_FRAMES = 1'b1;

    // Reset value of the phase step: 1.0 in 4.16.
    localparam logic [STEP_W-1:0] PHASE_STEP_RESET = 20'h10000;

    // Saturation limits of the mixed sample.
    localparam logic [SAMPLE_W-1:0] SAT_POS = 16'h7FFF;
    localparam logic [SAMPLE_W-1:0] SAT_NEG = 16'h8000;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch_item;
        logic mem_wr;
        logic start;
        logic stop;
        logic end_stop;
        logic rd_a;
        logic rd_b;
        logic latch_a;
        logic mul;
        logic acc;
        logic load_out;
    } rvm_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic             mix_ok;
    } rvm_sts_t;

endpackage

### design/rvm_in_if.sv
interface rvm_in_if;
    logic                                valid;
    logic                                ready;
    logic [rvm_pkg::ACT_W-1:0]           action;
    logic [rvm_pkg::INDEX_W-1:0]         sample_index;
    logic signed [rvm_pkg::SAMPLE_W-1:0] sample_value;
    logic signed [rvm_pkg::SAMPLE_W-1:0] mix_in;

    modport source (output valid, action, sample_index, sample_value, mix_in, input ready);
    modport sink (input valid, action, sample_index, sample_value, mix_in, output ready);
endinterface

### design/rvm_out_if.sv
interface rvm_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [rvm_pkg::SAMPLE_W-1:0] mix_out;
    logic                                sample_mixed;
    logic                                is_playing;

    modport source (output valid, mix_out, sample_mixed, is_playing, input ready);
    modport sink (input valid, mix_out, sample_mixed, is_playing, output ready);
endinterface

### design/rvm_datapath.sv
module rvm_datapath #(
    parameter int SAMPLE_DEPTH = 4096
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  rvm_pkg::rvm_cmd_t                    cmd,
    output rvm_pkg::rvm_sts_t                    sts,
    input  logic [rvm_pkg::ACT_W-1:0]            in_action,
    input  logic [rvm_pkg::INDEX_W-1:0]          in_sample_index,
    input  logic signed [rvm_pkg::SAMPLE_W-1:0]  in_sample_value,
    input  logic signed [rvm_pkg::SAMPLE_W-1:0]  in_mix_in,
    input  logic                                 cfg_we,
    input  logic [rvm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [rvm_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    output logic signed [rvm_pkg::SAMPLE_W-1:0]  mix_out,
    output logic                                 sample_mixed,
    output logic                                 is_playing
);

    localparam int AW = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
    localparam int CW = (AW + 1 > 17) ? AW + 1 : 17;

    // Latched item.
    logic [rvm_pkg::ACT_W-1:0]           act_reg;
    logic [rvm_pkg::INDEX_W-1:0]         index_reg;
    logic [rvm_pkg::SAMPLE_W-1:0]        value_reg;
    logic signed [rvm_pkg::SAMPLE_W-1:0] mix_in_reg;

    // Configuration and playback state.
    logic [rvm_pkg::STEP_W-1:0]   phase_step_reg;
    logic [rvm_pkg::FRAMES_W-1:0] clip_frames_reg;
    logic [rvm_pkg::POS_W-1:0]    pos_reg;
    logic                         playing_reg;

    // Sample memory and interpolation registers.
    logic [rvm_pkg::SAMPLE_W-1:0]        mem [SAMPLE_DEPTH];
    logic [rvm_pkg::SAMPLE_W-1:0]        rdata_reg;
    logic signed [rvm_pkg::SAMPLE_W-1:0] a_reg;
    logic signed [33:0]                  prod_reg;

    // Result and output registers.
    logic signed [rvm_pkg::SAMPLE_W-1:0] res_mix_reg;
    logic                                res_mixed_reg;
    logic signed [rvm_pkg::SAMPLE_W-1:0] out_mix_reg;
    logic                                out_mixed_reg;
    logic                                out_playing_reg;

    logic [CW-1:0]         idx_ext;
    logic [CW-1:0]         nxt_ext;
    logic [CW-1:0]         frames_raw;
    logic [CW-1:0]         depth_c;
    logic [CW-1:0]         frames_eff;
    logic [CW-1:0]         rd_ext;
    logic [CW-1:0]         wr_ext;
    logic                  has_next;
    logic                  load_ok;
    logic signed [16:0]    diff;
    logic signed [16:0]    frac_s;
    logic signed [17:0]    interp;
    logic signed [18:0]    sum;
    logic signed [rvm_pkg::SAMPLE_W-1:0] sat;

    // Position compare against the effective clip length.
    assign idx_ext    = CW'(pos_reg[rvm_pkg::POS_W-1:rvm_pkg::FRAC_W]);
    assign nxt_ext    = idx_ext + CW'(1);
    assign frames_raw = CW'(clip_frames_reg);
    assign depth_c    = CW'(SAMPLE_DEPTH);
    assign frames_eff = (frames_raw > depth_c) ? depth_c : frames_raw;
    assign has_next   = nxt_ext < frames_eff;
    assign wr_ext     = CW'(index_reg);
    assign load_ok    = wr_ext < depth_c;
    assign rd_ext     = (cmd.rd_b && has_next) ? nxt_ext : idx_ext;

    assign sts.action = act_reg;
    assign sts.mix_ok = playing_reg && (idx_ext < frames_eff);

    // Interpolation arithmetic: the second frame is in rdata_reg during the multiply.
    assign diff   = $signed({rdata_reg[rvm_pkg::SAMPLE_W-1], rdata_reg})
                  - $signed({a_reg[rvm_pkg::SAMPLE_W-1], a_reg});
    assign frac_s = $signed({1'b0, pos_reg[rvm_pkg::FRAC_W-1:0]});
    assign interp = prod_reg[33:16];
    assign sum    = 19'(a_reg) + 19'(interp) + 19'(mix_in_reg);

    // Saturate the mixed sum to 16 bits.
    always_comb
    begin
        if (sum > 19'sd32767)
        begin
            sat = $signed(rvm_pkg::SAT_POS);
        end
        else if (sum < -19'sd32768)
        begin
            sat = $signed(rvm_pkg::SAT_NEG);
        end
        else
        begin
            sat = sum[rvm_pkg::SAMPLE_W-1:0];
        end
    end

    // Item latch and interpolation registers.
    always_ff @(posedge clk)
    begin
        if (cmd.latch_item)
        begin
            act_reg    <= in_action;
            index_reg  <= in_sample_index;
            value_reg  <= in_sample_value;
            mix_in_reg <= in_mix_in;
        end
        if (cmd.latch_a)
        begin
            a_reg <= $signed(rdata_reg);
        end
        if (cmd.mul)
        begin
            prod_reg <= diff * frac_s;
        end
    end

    // Single-port sample memory with registered read data.
    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr && load_ok)
        begin
            mem[wr_ext[AW-1:0]] <= value_reg;
        end
        if (cmd.rd_a || cmd.rd_b)
        begin
            rdata_reg <= mem[rd_ext[AW-1:0]];
        end
    end

    // Configuration registers, position and playing flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg  <= rvm_pkg::PHASE_STEP_RESET;
            clip_frames_reg <= '0;
            pos_reg         <= '0;
            playing_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    rvm_pkg::CFG_PHASE_STEP:  phase_step_reg  <= cfg_wdata;
                    rvm_pkg::CFG_CLIP_FRAMES: clip_frames_reg <= cfg_wdata[rvm_pkg::FRAMES_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.start)
            begin
                pos_reg     <= '0;
                playing_reg <= (clip_frames_reg != '0) && (phase_step_reg != '0);
            end
            if (cmd.stop || cmd.end_stop)
            begin
                playing_reg <= 1'b0;
            end
            if (cmd.acc)
            begin
                pos_reg <= pos_reg + rvm_pkg::POS_W'(phase_step_reg);
            end
        end
    end

    // Result staging and the output register.
    always_ff @(posedge clk)
    begin
        if (cmd.latch_item)
        begin
            res_mix_reg   <= in_mix_in;
            res_mixed_reg <= 1'b0;
        end
        else if (cmd.acc)
        begin
            res_mix_reg   <= sat;
            res_mixed_reg <= 1'b1;
        end
        if (cmd.load_out)
        begin
            out_mix_reg     <= res_mix_reg;
            out_mixed_reg   <= res_mixed_reg;
            out_playing_reg <= playing_reg;
        end
    end

    assign mix_out      = out_mix_reg;
    assign sample_mixed = out_mixed_reg;
    assign is_playing   = out_playing_reg;

`ifndef NO_ASSERTIONS
    // A first-frame read is only issued for a frame inside the clip.
    a_rd_in_clip: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_a |-> sts.mix_ok)
        else $error("sample read issued outside the clip");

    // The accumulate step leaves a mixed result.
    a_acc_mixed: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.acc |=> res_mixed_reg)
        else $error("accumulate did not mark the result as mixed");

    // Stopping at the end of the clip clears the flag.
    a_end_stop: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.end_stop |=> !playing_reg)
        else $error("playing flag still set after end of clip");
`endif

endmodule

### design/rvm_ctrl.sv
module rvm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  rvm_pkg::rvm_sts_t sts,
    output rvm_pkg::rvm_cmd_t cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_RDB  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_ACC  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // Sequencer: decode the item, run the two reads and the math for a playing mix item, then deliver.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch_item = 1'b1;
                    state_next     = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_DONE;
                unique case (sts.action)
                    rvm_pkg::ACT_LOAD:  cmd.mem_wr = 1'b1;
                    rvm_pkg::ACT_START: cmd.start  = 1'b1;
                    rvm_pkg::ACT_STOP:  cmd.stop   = 1'b1;
                    rvm_pkg::ACT_MIX:
                    begin
                        if (sts.mix_ok)
                        begin
                            cmd.rd_a   = 1'b1;
                            state_next = S_RDB;
                        end
                        else
                        begin
                            cmd.end_stop = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            S_RDB:
            begin
                cmd.latch_a = 1'b1;
                cmd.rd_b    = 1'b1;
                state_next  = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid flag of the result register.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef NO_ASSERTIONS
    // The second read always follows the first.
    a_rdb_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RDB) |-> ($past(state_reg) == S_EXEC))
        else $error("second read without a first read");

    // The accumulate step always follows the multiply.
    a_acc_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ACC) |-> ($past(state_reg) == S_MUL))
        else $error("accumulate without multiply");

    // A result is never written over one that has not been taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("output register overwritten");

    // An accepted item is decoded in the next cycle.
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_EXEC))
        else $error("accepted item not decoded");
`endif

endmodule

### design/resampling_voice_mixer_core.sv
// Sequence: an accepted item is latched and decoded in S_EXEC; a load, start, stop or idle
// mix item goes to S_DONE; a mix item that plays a frame passes S_RDB, S_MUL and S_ACC,
// doing the two sequential reads of the single-port sample memory, multiply and accumulate.
// S_DONE waits until the output register is free or taken; only S_IDLE accepts an item.
// Reset: rst_n clears control, position and playing flag, sets the phase step to 1.0 and the
// clip length to 0; the sample memory is not cleared and has no clearing pass.
module resampling_voice_mixer_core #(
    parameter int SAMPLE_DEPTH = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    rvm_in_if.sink                              in_ch,
    rvm_out_if.source                           out_ch,
    input  logic                                cfg_we,
    input  logic [rvm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rvm_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    rvm_pkg::rvm_cmd_t cmd;
    rvm_pkg::rvm_sts_t sts;

    // Controller state machine.
    rvm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Sample memory, interpolation and mixing datapath.
    rvm_datapath #(
        .SAMPLE_DEPTH (SAMPLE_DEPTH)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .in_action       (in_ch.action),
        .in_sample_index (in_ch.sample_index),
        .in_sample_value (in_ch.sample_value),
        .in_mix_in       (in_ch.mix_in),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .mix_out         (out_ch.mix_out),
        .sample_mixed    (out_ch.sample_mixed),
        .is_playing      (out_ch.is_playing)
    );

endmodule
